[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is asserted
`define YRGB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("yrgb assertion failed");

// clocked assertion that is also checked during reset
`define YRGB_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("yrgb assertion failed");

`endif

[hw/rtl/yrgb_pkg.sv]
// shared types and constants of the ycbcr to rgba converter with block statistics
package yrgb_pkg;

  // macroblock geometry
  localparam int unsigned BLOCK_PIXELS = 64;
  localparam int unsigned PIX_LOG2     = $clog2(BLOCK_PIXELS);

  // fixed point conversion
  localparam int unsigned Q_FRAC = 10;
  localparam int unsigned ACC_W  = 21;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SUM_W  = 16;

  localparam logic signed [ACC_W-1:0] K_R_CR     = ACC_W'(1436);
  localparam logic signed [ACC_W-1:0] K_G_CB     = ACC_W'(352);
  localparam logic signed [ACC_W-1:0] K_G_CR     = ACC_W'(732);
  localparam logic signed [ACC_W-1:0] K_B_CB     = ACC_W'(1815);
  localparam logic signed [ACC_W-1:0] CHROMA_OFS = ACC_W'(128);
  localparam logic [CHAN_W-1:0]       CHAN_MAX   = 8'd255;
  localparam logic [CHAN_W-1:0]       ALPHA      = 8'd255;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE  = 1'b0,
    CFG_BLOCKS_LOG2 = 1'b1
  } cfg_idx_e;

  // converted pixel
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  // macroblock statistics carried with a result
  typedef struct packed {
    logic              stats_valid;
    logic [CHAN_W-1:0] min_red;
    logic [CHAN_W-1:0] min_green;
    logic [CHAN_W-1:0] min_blue;
    logic [CHAN_W-1:0] avg_red;
    logic [CHAN_W-1:0] avg_green;
    logic [CHAN_W-1:0] avg_blue;
    logic [CHAN_W-1:0] max_red;
    logic [CHAN_W-1:0] max_green;
    logic [CHAN_W-1:0] max_blue;
  } blk_stats_t;

endpackage

[hw/rtl/yrgb_if.sv]
// channel interfaces: pixel input, result output and configuration write
interface yrgb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;
  logic       last_in_block;

  modport source (output valid, luma, chroma_blue, chroma_red, last_in_block, input ready);
  modport sink (input valid, luma, chroma_blue, chroma_red, last_in_block, output ready);
endinterface

interface yrgb_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] rgba;
  logic        stats_valid;
  logic [7:0]  min_red;
  logic [7:0]  min_green;
  logic [7:0]  min_blue;
  logic [7:0]  avg_red;
  logic [7:0]  avg_green;
  logic [7:0]  avg_blue;
  logic [7:0]  max_red;
  logic [7:0]  max_green;
  logic [7:0]  max_blue;

  modport source (output valid, rgba, stats_valid, min_red, min_green, min_blue,
                  avg_red, avg_green, avg_blue, max_red, max_green, max_blue,
                  input ready);
  modport sink (input valid, rgba, stats_valid, min_red, min_green, min_blue,
                avg_red, avg_green, avg_blue, max_red, max_green, max_blue,
                output ready);
endinterface

interface yrgb_cfg_if;
  logic       valid;
  logic       ready;
  logic       idx;
  logic [1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

[hw/rtl/yrgb_convert.sv]
// ycbcr to rgb conversion in q10 fixed point with clamping, or gray replicate
module yrgb_convert
  import yrgb_pkg::*;
(
  input  logic              color_mode_i,
  input  logic [CHAN_W-1:0] luma_i,
  input  logic [CHAN_W-1:0] chroma_blue_i,
  input  logic [CHAN_W-1:0] chroma_red_i,
  output rgb_t              rgb_o
);

  logic signed [ACC_W-1:0] y_x;
  logic signed [ACC_W-1:0] cb_x;
  logic signed [ACC_W-1:0] cr_x;
  logic signed [ACC_W-1:0] r_acc;
  logic signed [ACC_W-1:0] g_acc;
  logic signed [ACC_W-1:0] b_acc;

  // floor shift by the fraction width, clamp to 0..255
  function automatic logic [CHAN_W-1:0] clamp_q(input logic signed [ACC_W-1:0] v);
    logic [CHAN_W-1:0] res;
    if (v[ACC_W-1]) begin
      res = '0;
    end else if (|v[ACC_W-2:Q_FRAC+CHAN_W]) begin
      res = CHAN_MAX;
    end else begin
      res = v[Q_FRAC+CHAN_W-1:Q_FRAC];
    end
    return res;
  endfunction

  // luma in q10, chroma with offset removed
  assign y_x  = $signed({{(ACC_W-CHAN_W-Q_FRAC){1'b0}}, luma_i, {Q_FRAC{1'b0}}});
  assign cb_x = $signed({{(ACC_W-CHAN_W){1'b0}}, chroma_blue_i}) - CHROMA_OFS;
  assign cr_x = $signed({{(ACC_W-CHAN_W){1'b0}}, chroma_red_i}) - CHROMA_OFS;

  // jfif equations
  assign r_acc = y_x + K_R_CR * cr_x;
  assign g_acc = y_x - K_G_CB * cb_x - K_G_CR * cr_x;
  assign b_acc = y_x + K_B_CB * cb_x;

  // channel select by mode
  always_comb begin
    if (color_mode_i) begin
      rgb_o.red   = clamp_q(r_acc);
      rgb_o.green = clamp_q(g_acc);
      rgb_o.blue  = clamp_q(b_acc);
    end else begin
      rgb_o.red   = luma_i;
      rgb_o.green = luma_i;
      rgb_o.blue  = luma_i;
    end
  end

endmodule

[hw/rtl/yrgb_stats.sv]
// per-macroblock running min, max and sum of r, g and b with block report
module yrgb_stats
  import yrgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       color_mode_i,
  input  logic [1:0] blocks_log2_i,
  input  rgb_t       pix_i,
  input  logic       last_i,
  output blk_stats_t stats_o
);

  `include "assert_macros.svh"

  localparam int unsigned NCH = 3;

  logic [NCH-1:0][CHAN_W-1:0] chan;
  logic [NCH-1:0][SUM_W-1:0]  sum_q, sum_d, sum_new;
  logic [NCH-1:0][CHAN_W-1:0] low_q, low_d, low_new;
  logic [NCH-1:0][CHAN_W-1:0] high_q, high_d, high_new;
  logic [NCH-1:0][SUM_W-1:0]  avg_sh;
  logic [NCH-1:0][CHAN_W-1:0] avg;
  logic [1:0]                 extra;
  logic [3:0]                 shift;
  logic                       report;

  assign chan = {pix_i.blue, pix_i.green, pix_i.red};

  // block size shift, saturating the extra part at two
  assign extra = (blocks_log2_i == 2'd3) ? 2'd2 : blocks_log2_i;
  assign shift = 4'(PIX_LOG2) + {2'b00, extra};

  // running values including the current pixel
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_new[c]  = sum_q[c] + SUM_W'(chan[c]);
      low_new[c]  = (chan[c] < low_q[c]) ? chan[c] : low_q[c];
      high_new[c] = (chan[c] > high_q[c]) ? chan[c] : high_q[c];
      avg_sh[c]   = sum_new[c] >> shift;
      avg[c]      = (avg_sh[c] > SUM_W'(CHAN_MAX)) ? CHAN_MAX : avg_sh[c][CHAN_W-1:0];
    end
  end

  // accumulator next state: clear on last, track in colour mode
  always_comb begin
    sum_d  = sum_q;
    low_d  = low_q;
    high_d = high_q;
    if (adv_i) begin
      if (last_i) begin
        sum_d  = '0;
        low_d  = {NCH{CHAN_MAX}};
        high_d = '0;
      end else if (color_mode_i) begin
        sum_d  = sum_new;
        low_d  = low_new;
        high_d = high_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      low_q  <= {NCH{CHAN_MAX}};
      high_q <= '0;
    end else begin
      sum_q  <= sum_d;
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // block report, zero when there is none
  assign report = last_i & color_mode_i;

  always_comb begin
    stats_o = '0;
    if (report) begin
      stats_o.stats_valid = 1'b1;
      stats_o.min_red     = low_new[0];
      stats_o.min_green   = low_new[1];
      stats_o.min_blue    = low_new[2];
      stats_o.avg_red     = avg[0];
      stats_o.avg_green   = avg[1];
      stats_o.avg_blue    = avg[2];
      stats_o.max_red     = high_new[0];
      stats_o.max_green   = high_new[1];
      stats_o.max_blue    = high_new[2];
    end
  end

  // accumulators are cleared after the last pixel of a block
  `YRGB_ASSERT(a_clear_after_last, (adv_i && last_i) |=> (sum_q == '0 && high_q == '0 && low_q == {NCH{CHAN_MAX}}))
  // gray pixels leave the accumulators alone
  `YRGB_ASSERT(a_gray_no_track, (adv_i && !last_i && !color_mode_i) |=> ($stable(sum_q) && $stable(low_q) && $stable(high_q)))

endmodule

[hw/rtl/ycbcr_to_rgba_with_block_stats_unit.sv]
// top level of the ycbcr to rgba converter with macroblock statistics
//
// usage:
// - pix_i takes one pixel per transaction: luma, chroma_blue, chroma_red and
//   last_in_block marking the final pixel of a macroblock
// - res_o gives exactly one result per pixel, in order: packed rgba and, on a
//   last pixel in colour mode, min / average / max of r, g and b over the block
// - cfg_i writes color_mode (index 0) and luma_blocks_log2 (index 1); it is
//   always ready; the user must write it only while no pixel is in flight,
//   as the block does not enforce this
// - a pixel passes the input register, the conversion register and the
//   statistics and output register in that order before its result is offered
// - throughput is one pixel per cycle while the receiver is ready; the three
//   registers are pipeline slots, each taking new data when empty or moving on
// - when the receiver stalls, results hold and the pipeline fills, then
//   pix_i.ready drops; nothing is lost or repeated
// - reset empties the pipeline, sets colour mode, a one-block macroblock, and
//   clears the min, max and sum accumulators
module ycbcr_to_rgba_with_block_stats_unit
  import yrgb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  yrgb_pix_if.sink   pix_i,
  yrgb_cfg_if.sink   cfg_i,
  yrgb_res_if.source res_o
);

  `include "assert_macros.svh"

  // configuration registers
  logic       color_mode_q;
  logic [1:0] blocks_log2_q;

  // stage 1: input register
  logic              v1_q;
  logic [CHAN_W-1:0] y1_q, cb1_q, cr1_q;
  logic              last1_q;

  // stage 2: converted pixel
  logic   v2_q;
  rgb_t   rgb2_q;
  logic   last2_q;
  rgb_t   rgb_conv;

  // stage 3: output register
  logic        v3_q;
  logic [31:0] rgba3_q;
  blk_stats_t  stats3_q;
  blk_stats_t  stats_calc;

  logic ready1, ready2, ready3, adv3;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q  <= 1'b1;
      blocks_log2_q <= 2'd0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.idx))
        CFG_COLOR_MODE:  color_mode_q  <= cfg_i.data[0];
        CFG_BLOCKS_LOG2: blocks_log2_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign ready3      = !v3_q || res_o.ready;
  assign ready2      = !v2_q || ready3;
  assign ready1      = !v1_q || ready2;
  assign adv3        = v2_q && ready3;
  assign pix_i.ready = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= pix_i.valid;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (ready1 && pix_i.valid) begin
      y1_q    <= pix_i.luma;
      cb1_q   <= pix_i.chroma_blue;
      cr1_q   <= pix_i.chroma_red;
      last1_q <= pix_i.last_in_block;
    end
  end

  // stage 2: colour conversion
  yrgb_convert u_convert (
    .color_mode_i  (color_mode_q),
    .luma_i        (y1_q),
    .chroma_blue_i (cb1_q),
    .chroma_red_i  (cr1_q),
    .rgb_o         (rgb_conv)
  );

  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q) begin
      rgb2_q  <= rgb_conv;
      last2_q <= last1_q;
    end
  end

  // stage 3: statistics and output
  yrgb_stats u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv3),
    .color_mode_i  (color_mode_q),
    .blocks_log2_i (blocks_log2_q),
    .pix_i         (rgb2_q),
    .last_i        (last2_q),
    .stats_o       (stats_calc)
  );

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      rgba3_q  <= {ALPHA, rgb2_q.blue, rgb2_q.green, rgb2_q.red};
      stats3_q <= stats_calc;
    end
  end

  // result channel
  assign res_o.valid       = v3_q;
  assign res_o.rgba        = rgba3_q;
  assign res_o.stats_valid = stats3_q.stats_valid;
  assign res_o.min_red     = stats3_q.min_red;
  assign res_o.min_green   = stats3_q.min_green;
  assign res_o.min_blue    = stats3_q.min_blue;
  assign res_o.avg_red     = stats3_q.avg_red;
  assign res_o.avg_green   = stats3_q.avg_green;
  assign res_o.avg_blue    = stats3_q.avg_blue;
  assign res_o.max_red     = stats3_q.max_red;
  assign res_o.max_green   = stats3_q.max_green;
  assign res_o.max_blue    = stats3_q.max_blue;

  // a block report always has min not above max
  `YRGB_ASSERT(a_min_le_max, (v3_q && stats3_q.stats_valid) |->
    (stats3_q.min_red <= stats3_q.max_red && stats3_q.min_green <= stats3_q.max_green &&
     stats3_q.min_blue <= stats3_q.max_blue))
  // a full pipeline with a stalled receiver refuses new pixels
  `YRGB_ASSERT(a_full_stall, (v1_q && v2_q && v3_q && !res_o.ready) |-> !pix_i.ready)
  // no result is offered while reset is held
  `YRGB_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!v1_q && !v2_q && !v3_q))

endmodule
